@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the decompressor core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/lzss_pkg.sv @@
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Request types, parser codes and fixed constants of the decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

  // Default configuration of the core.
  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int LENGTH_BITS_DEF  = 16;

  // Fixed widths of the token format and the length register.
  localparam int TOTAL_LEN_W = 16;
  localparam int DIST_W      = 12;
  localparam int COUNT_W     = 4;
  localparam int FLAG_CNT_W  = 4;
  localparam int FLAGS_PER_BYTE = 8;

  // One compressed input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } lzss_in_t;

  // One decompressed result request.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
    logic       bad_reference;
  } lzss_out_t;

  // What the parser expects as the next compressed byte.
  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_ITEM = 2'd1,
    PH_LOW  = 2'd2
  } lzss_phase_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EMIT = 2'd2
  } lzss_state_t;

endpackage

@@ rtl/core/lzss_window_ram.sv @@
// ----------------------------------------------------------------------------
// LZSS history window memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module lzss_window_ram #(
  parameter int DEPTH = lzss_pkg::WINDOW_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/lzss_ctrl.sv @@
// ----------------------------------------------------------------------------
// LZSS parser and copy sequencer
// Parses flag bytes, literals and tokens, drives the window memory and holds
// the result output register.
// ----------------------------------------------------------------------------
module lzss_ctrl #(
  parameter int WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH_DEF,
  parameter int LENGTH_BITS  = lzss_pkg::LENGTH_BITS_DEF,
  parameter int AW           = $clog2(WINDOW_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [lzss_pkg::TOTAL_LEN_W-1:0] total_length,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lzss_pkg::lzss_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lzss_pkg::lzss_out_t              out_data,
  output logic                             mem_wr_en,
  output logic [AW-1:0]                    mem_wr_addr,
  output logic [7:0]                       mem_wr_data,
  output logic                             mem_rd_en,
  output logic [AW-1:0]                    mem_rd_addr,
  input  logic [7:0]                       mem_rd_data
);

  localparam int LB  = LENGTH_BITS;
  localparam int CW  = (LB > lzss_pkg::TOTAL_LEN_W) ? LB : lzss_pkg::TOTAL_LEN_W;
  localparam int AW1 = AW + 1;
  localparam int DW  = lzss_pkg::DIST_W;
  localparam int NW  = lzss_pkg::COUNT_W;
  localparam int FW  = lzss_pkg::FLAG_CNT_W;

  // Registers.
  lzss_pkg::lzss_state_t state_r, state_nxt;
  lzss_pkg::lzss_phase_t phase_r, phase_nxt;
  logic [7:0]            flag_bits_r, flag_bits_nxt;
  logic [FW-1:0]         flags_left_r, flags_left_nxt;
  logic [7:0]            token_high_r, token_high_nxt;
  logic [LB-1:0]         bw_r, bw_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [AW-1:0]         src_r, src_nxt;
  logic [NW-1:0]         cnt_r, cnt_nxt;
  logic                  bad_r, bad_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lzss_pkg::lzss_out_t   out_data_r, out_data_nxt;

  // Handshake and stream-start view of the state.
  logic                  out_free;
  logic                  acc;
  logic                  clr;
  lzss_pkg::lzss_phase_t phase_e;
  logic [7:0]            flag_bits_e;
  logic [FW-1:0]         flags_left_e;
  logic [7:0]            token_high_e;
  logic [LB-1:0]         bw_e;
  logic [AW-1:0]         wp_e;
  logic                  complete;

  // Token decode.
  logic [DW-1:0]  tok_dist;
  logic [NW-1:0]  count;
  logic           bad_calc;
  logic [AW1-1:0] wp_ext;
  logic [AW1-1:0] dist_ext;
  logic [AW-1:0]  src_calc;

  // Flag advance.
  logic [7:0]            nf_bits;
  logic [FW-1:0]         nf_left;
  lzss_pkg::lzss_phase_t nf_phase;

  // Shared emit path.
  logic          emit_en;
  logic [7:0]    emit_byte;
  logic          emit_bad;
  logic          emit_last;
  logic [LB-1:0] bw_base;
  logic [AW-1:0] wp_base;
  logic [LB-1:0] bw_inc;
  logic [AW-1:0] wp_inc;
  logic          copy_stop;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == lzss_pkg::ST_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign clr      = acc && in_data.stream_start;

  // A new stream clears the parse state before its first byte is taken.
  assign phase_e      = clr ? lzss_pkg::PH_FLAG : phase_r;
  assign flag_bits_e  = clr ? 8'd0 : flag_bits_r;
  assign flags_left_e = clr ? '0 : flags_left_r;
  assign token_high_e = clr ? 8'd0 : token_high_r;
  assign bw_e         = clr ? '0 : bw_r;
  assign wp_e         = clr ? '0 : wp_r;
  assign complete     = CW'(bw_e) >= CW'(total_length);

  // Token decode: upper twelve bits are the distance, low four the count.
  assign tok_dist = {token_high_e, in_data.in_byte[7:4]};
  assign count    = in_data.in_byte[NW-1:0];
  assign bad_calc = (tok_dist == '0) || (CW'(tok_dist) > CW'(bw_e));
  assign wp_ext   = AW1'(wp_e);
  assign dist_ext = AW1'(tok_dist);

  // Source position modulo the window depth.
  always_comb begin
    if (wp_ext >= dist_ext) begin
      src_calc = AW'(wp_ext - dist_ext);
    end else begin
      src_calc = AW'(wp_ext + AW1'(WINDOW_DEPTH) - dist_ext);
    end
  end

  // Step to the next flag of the current flag byte.
  assign nf_bits  = flag_bits_e >> 1;
  assign nf_left  = (flags_left_e == '0) ? '0 : flags_left_e - FW'(1);
  assign nf_phase = (nf_left == '0) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_ITEM;

  // Write position and byte count after one emitted byte.
  assign bw_base = (state_r == lzss_pkg::ST_IDLE) ? bw_e : bw_r;
  assign wp_base = (state_r == lzss_pkg::ST_IDLE) ? wp_e : wp_r;
  assign bw_inc  = bw_base + LB'(1);
  always_comb begin
    if (bw_inc == '0) begin
      wp_inc = '0;
    end else if (wp_base == AW'(WINDOW_DEPTH - 1)) begin
      wp_inc = '0;
    end else begin
      wp_inc = wp_base + AW'(1);
    end
  end
  assign copy_stop = (cnt_r == NW'(1)) || (CW'(bw_inc) >= CW'(total_length));

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzss_pkg::ST_IDLE: begin
        if (acc && !complete && (phase_e == lzss_pkg::PH_LOW) && (count != '0)) begin
          state_nxt = bad_calc ? lzss_pkg::ST_EMIT : lzss_pkg::ST_READ;
        end
      end
      lzss_pkg::ST_READ: begin
        state_nxt = lzss_pkg::ST_EMIT;
      end
      lzss_pkg::ST_EMIT: begin
        if (out_free) begin
          if (copy_stop) begin
            state_nxt = lzss_pkg::ST_IDLE;
          end else begin
            state_nxt = bad_r ? lzss_pkg::ST_EMIT : lzss_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = lzss_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    phase_nxt      = phase_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    token_high_nxt = token_high_r;
    bw_nxt         = bw_r;
    wp_nxt         = wp_r;
    src_nxt        = src_r;
    cnt_nxt        = cnt_r;
    bad_nxt        = bad_r;
    emit_en        = 1'b0;
    emit_byte      = 8'd0;
    emit_bad       = 1'b0;
    emit_last      = 1'b0;
    mem_rd_en      = 1'b0;

    case (state_r)
      lzss_pkg::ST_IDLE: begin
        if (acc) begin
          phase_nxt      = phase_e;
          flag_bits_nxt  = flag_bits_e;
          flags_left_nxt = flags_left_e;
          token_high_nxt = token_high_e;
          bw_nxt         = bw_e;
          wp_nxt         = wp_e;
          if (!complete) begin
            case (phase_e)
              lzss_pkg::PH_FLAG: begin
                flag_bits_nxt  = in_data.in_byte;
                flags_left_nxt = FW'(lzss_pkg::FLAGS_PER_BYTE);
                phase_nxt      = lzss_pkg::PH_ITEM;
              end
              lzss_pkg::PH_ITEM: begin
                if (flag_bits_e[0]) begin
                  token_high_nxt = in_data.in_byte;
                  phase_nxt      = lzss_pkg::PH_LOW;
                end else begin
                  emit_en        = 1'b1;
                  emit_byte      = in_data.in_byte;
                  emit_last      = 1'b1;
                  flag_bits_nxt  = nf_bits;
                  flags_left_nxt = nf_left;
                  phase_nxt      = nf_phase;
                end
              end
              lzss_pkg::PH_LOW: begin
                flag_bits_nxt  = nf_bits;
                flags_left_nxt = nf_left;
                phase_nxt      = nf_phase;
                cnt_nxt        = count;
                src_nxt        = src_calc;
                bad_nxt        = bad_calc;
              end
              default: begin
                phase_nxt = lzss_pkg::PH_FLAG;
              end
            endcase
          end
        end
      end
      lzss_pkg::ST_READ: begin
        // Fetch one history byte and advance the source position.
        mem_rd_en = 1'b1;
        src_nxt   = (src_r == AW'(WINDOW_DEPTH - 1)) ? '0 : src_r + AW'(1);
      end
      lzss_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_byte = bad_r ? 8'd0 : mem_rd_data;
          emit_bad  = bad_r;
          emit_last = copy_stop;
          cnt_nxt   = cnt_r - NW'(1);
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase

    // Every emitted byte also enters the history window.
    if (emit_en) begin
      bw_nxt = bw_inc;
      wp_nxt = wp_inc;
    end
  end

  assign mem_wr_en   = emit_en;
  assign mem_wr_addr = wp_base;
  assign mem_wr_data = emit_byte;
  assign mem_rd_addr = src_r;

  // Output register load and drain.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_en) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.out_byte      = emit_byte;
      out_data_nxt.last_of_run   = emit_last;
      out_data_nxt.stream_done   = CW'(bw_inc) == CW'(total_length);
      out_data_nxt.bad_reference = emit_bad;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lzss_pkg::ST_IDLE;
      phase_r      <= lzss_pkg::PH_FLAG;
      flag_bits_r  <= 8'd0;
      flags_left_r <= '0;
      token_high_r <= 8'd0;
      bw_r         <= '0;
      wp_r         <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      token_high_r <= token_high_nxt;
      bw_r         <= bw_nxt;
      wp_r         <= wp_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/lzss_12_4_decompressor_core.sv @@
// ----------------------------------------------------------------------------
// LZSS 12/4 decompressor core
// A literal is shown in the cycle after its request is taken; a copy's first
// byte passes READ, the registered window read and EMIT (a bad reference
// skips READ). Copies alternate READ and EMIT, paced by the registered read of
// the history window RAM; bad-reference copies run one byte a cycle while
// the output is free. Reset clears the parser, counters and length register;
// the window is not cleared, so there is no start-up sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzss_12_4_decompressor_core #(
  parameter int WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH_DEF,
  parameter int LENGTH_BITS  = lzss_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lzss_pkg::TOTAL_LEN_W-1:0] cfg_total_length,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lzss_pkg::lzss_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lzss_pkg::lzss_out_t              out_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [lzss_pkg::TOTAL_LEN_W-1:0] total_len_r;
  logic                             mem_wr_en;
  logic [AW-1:0]                    mem_wr_addr;
  logic [7:0]                       mem_wr_data;
  logic                             mem_rd_en;
  logic [AW-1:0]                    mem_rd_addr;
  logic [7:0]                       mem_rd_data;

  // Length register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_len_r <= '0;
    end else if (cfg_valid) begin
      total_len_r <= cfg_total_length;
    end
  end

  // Parser and copy sequencer.
  lzss_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .LENGTH_BITS  (LENGTH_BITS),
    .AW           (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .total_length (total_len_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  // History window.
  lzss_window_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_window (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // A pending copy byte that is not the last one keeps the input closed.
  `ASSERT_SAME(a_copy_blocks_input, clk, rst_n, out_valid && !out_data.last_of_run, !in_ready)

  // The first byte of a stream is a flag byte and yields no result.
  `ASSERT_NEXT(a_start_no_result, clk, rst_n, in_valid && in_ready && in_data.stream_start && out_ready, !out_valid)

  // The byte that completes the stream always closes its run.
  `ASSERT_SAME(a_done_is_last, clk, rst_n, out_valid && out_data.stream_done, out_data.last_of_run)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS 12/4 decompressor core testbench
// Drives compressed streams into the core, rebuilds the expected output bytes
// from its own decoder state and compares each result request with them.
// Directed streams cover literals, overlapping and bad copies, zero counts,
// truncation at the total length and restarts; random streams follow under
// several length settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_CYCLES = 48;
  localparam int LONG_HOLD    = 400;

  // Decoder state mirror and the queue of bytes the core still owes us.
  class lzss_decode_tracker;
    logic [7:0]            window [lzss_pkg::WINDOW_DEPTH_DEF];
    logic [15:0]           written;
    logic [15:0]           total_len;
    logic [7:0]            flags;
    logic [3:0]            flags_left;
    logic [7:0]            tok_hi;
    lzss_pkg::lzss_phase_t phase;
    lzss_pkg::lzss_out_t   decoded_bytes [$];
    int                    mismatches;

    function new();
      written    = '0;
      total_len  = '0;
      flags      = '0;
      flags_left = '0;
      tok_hi     = '0;
      phase      = lzss_pkg::PH_FLAG;
      mismatches = 0;
    endfunction

    function void set_length(logic [15:0] len);
      total_len = len;
    endfunction

    function int pending();
      return decoded_bytes.size();
    endfunction

    // Append one output byte and record it in the history window.
    function void push_byte(logic [7:0] v, bit bad);
      lzss_pkg::lzss_out_t r;
      window[int'(written) % lzss_pkg::WINDOW_DEPTH_DEF] = v;
      written = written + 16'd1;
      r.out_byte      = v;
      r.last_of_run   = 1'b0;
      r.stream_done   = (written == total_len);
      r.bad_reference = bad;
      decoded_bytes.push_back(r);
    endfunction

    function void advance_flag();
      flags = flags >> 1;
      if (flags_left != 0) flags_left = flags_left - 4'd1;
      phase = (flags_left == 0) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_ITEM;
    endfunction

    // Returns 1 when the request is actually decoded, 0 when it is swallowed.
    function bit take_request(lzss_pkg::lzss_in_t req);
      logic [11:0]         tok_dist;
      logic [3:0]          cnt;
      logic [15:0]         src;
      bit                  bad;
      int                  before_cnt;
      lzss_pkg::lzss_out_t tail;
      if (req.stream_start) begin
        written    = '0;
        flags      = '0;
        flags_left = '0;
        phase      = lzss_pkg::PH_FLAG;
        tok_hi     = '0;
      end
      if (written >= total_len) return 1'b0;
      before_cnt = decoded_bytes.size();
      case (phase)
        lzss_pkg::PH_ITEM: begin
          if (flags[0]) begin
            tok_hi = req.in_byte;
            phase  = lzss_pkg::PH_LOW;
          end else begin
            push_byte(req.in_byte, 1'b0);
            advance_flag();
          end
        end
        lzss_pkg::PH_LOW: begin
          tok_dist = {tok_hi, req.in_byte[7:4]};
          cnt      = req.in_byte[3:0];
          bad      = (tok_dist == 0) || ({4'b0, tok_dist} > written);
          src      = written - {4'b0, tok_dist};
          // Byte-by-byte copy so an overlapping source repeats fresh bytes.
          while (cnt != 0 && written < total_len) begin
            push_byte(bad ? 8'h00 : window[int'(src) % lzss_pkg::WINDOW_DEPTH_DEF], bad);
            src = src + 16'd1;
            cnt = cnt - 4'd1;
          end
          advance_flag();
        end
        default: begin
          flags      = req.in_byte;
          flags_left = 4'd8;
          phase      = lzss_pkg::PH_ITEM;
        end
      endcase
      if (decoded_bytes.size() > before_cnt) begin
        tail = decoded_bytes.pop_back();
        tail.last_of_run = 1'b1;
        decoded_bytes.push_back(tail);
      end
      return 1'b1;
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(lzss_pkg::lzss_out_t got);
      lzss_pkg::lzss_out_t want;
      if (decoded_bytes.size() == 0) begin
        flag_error($sformatf("unexpected result byte %h last %b done %b bad %b",
                             got.out_byte, got.last_of_run, got.stream_done,
                             got.bad_reference));
        return;
      end
      want = decoded_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
          got.stream_done !== want.stream_done ||
          got.bad_reference !== want.bad_reference)
        flag_error($sformatf({"expected byte %h last %b done %b bad %b, ",
                              "got byte %h last %b done %b bad %b"},
                             want.out_byte, want.last_of_run, want.stream_done,
                             want.bad_reference, got.out_byte, got.last_of_run,
                             got.stream_done, got.bad_reference));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [15:0]         cfg_total_length;
  logic                in_valid;
  logic                in_ready;
  lzss_pkg::lzss_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  lzss_pkg::lzss_out_t out_data;

  lzss_decode_tracker model;
  bit                 tx_stall;
  bit                 rx_stall;
  bit                 long_hold;
  logic [11:0]        copy_dist;

  lzss_12_4_decompressor_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_total_length (cfg_total_length),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin : receiver
    int gap;
    out_ready <= 1'b0;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_stall && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every accepted result request is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) model.check_result(out_data);
  end

  // Offer one request, with an optional gap first, and wait for acceptance.
  task automatic send_request(lzss_pkg::lzss_in_t req, output bit decoded);
    int gap;
    if (tx_stall && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    decoded = model.take_request(req);
  endtask

  task automatic write_length(logic [15:0] len);
    cfg_valid        <= 1'b1;
    cfg_total_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model.set_length(len);
  endtask

  // Wait for every owed byte, then let any silent token finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Build the next byte of a mostly well-formed stream, steered by the
  // decoder state so that copies usually point at bytes already written.
  function automatic lzss_pkg::lzss_in_t next_stream_byte(bit long_mode);
    lzss_pkg::lzss_in_t req;
    int                 span;
    req.stream_start = 1'b0;
    req.in_byte      = 8'($urandom);
    if (!long_mode && $urandom_range(0, 19) == 0) begin
      // Stray byte, sometimes restarting the stream in the middle of a token.
      req.stream_start = 1'($urandom);
      return req;
    end
    if (model.written >= model.total_len) begin
      req.stream_start = 1'b1;
      return req;
    end
    case (model.phase)
      lzss_pkg::PH_FLAG: begin
        if (long_mode) req.in_byte = 8'($urandom) | 8'($urandom);
      end
      lzss_pkg::PH_ITEM: begin
        if (model.flags[0]) begin
          if (model.written != 0 && $urandom_range(0, 9) < 8) begin
            span = (model.written > 16'd4095) ? 4095 : int'(model.written);
            if (span > 16 && $urandom_range(0, 1) == 0) span = 16;
            copy_dist = 12'($urandom_range(1, span));
          end else begin
            copy_dist = 12'($urandom);
          end
          req.in_byte = copy_dist[11:4];
        end
      end
      default: begin
        req.in_byte = {copy_dist[3:0],
                       4'(long_mode ? $urandom_range(8, 15) : $urandom_range(0, 15))};
      end
    endcase
    return req;
  endfunction

  // Random streams until enough requests were decoded, or in long mode until
  // the stream reaches its total length.
  task automatic random_items(int goal, bit long_mode);
    lzss_pkg::lzss_in_t req;
    int                 taken;
    bit                 first_one;
    bit                 decoded;
    taken     = 0;
    first_one = 1'b1;
    while (taken < goal &&
           !(long_mode && !first_one && model.written >= model.total_len)) begin
      req = next_stream_byte(long_mode);
      if (first_one) req.stream_start = 1'b1;
      first_one = 1'b0;
      send_request(req, decoded);
      if (decoded) taken++;
    end
  endtask

  task automatic run_directed();
    lzss_pkg::lzss_in_t seq [$];
    bit                 decoded;
    // Length zero: the stream is complete at once and bytes are swallowed.
    write_length(16'd0);
    seq = '{'{8'hF2, 1'b1}, '{8'h5A, 1'b0}};
    foreach (seq[i]) send_request(seq[i], decoded);
    settle();
    write_length(16'd40);
    seq = '{
      '{8'hF2, 1'b1},                // flags: lit, tok, lit, lit, tok x4
      '{8'hFF, 1'b0},                // literal at the top of the range
      '{8'h00, 1'b0}, '{8'h05, 1'b0}, // distance zero: bad reference
      '{8'h00, 1'b0},                // literal zero
      '{8'hA5, 1'b0},
      '{8'h00, 1'b0}, '{8'h1F, 1'b0}, // distance one, full count: overlap
      '{8'h06, 1'b0}, '{8'h43, 1'b0}, // distance past the bytes written
      '{8'h00, 1'b0}, '{8'h20, 1'b0}, // count zero: nothing comes out
      '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, // largest token, cut at the total
      '{8'h12, 1'b0}, '{8'h34, 1'b0}, // stream complete: swallowed
      '{8'h01, 1'b1},                // restart on a fresh stream
      '{8'h00, 1'b0}, '{8'h1F, 1'b0}, // copy from an empty stream
      '{8'h7E, 1'b0}
    };
    foreach (seq[i]) send_request(seq[i], decoded);
    settle();
  endtask

  initial begin : stimulus
    model            = new();
    tx_stall         = 1'b1;
    rx_stall         = 1'b1;
    long_hold        = 1'b0;
    copy_dist        = '0;
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_total_length <= '0;
    in_valid         <= 1'b0;
    in_data          <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Mid-size streams with idling on both sides.
    write_length(16'd300);
    random_items(35, 1'b0);
    settle();

    // Largest length; the receiver holds off while the sender keeps going.
    write_length(16'hFFFF);
    tx_stall  = 1'b0;
    long_hold = 1'b1;
    random_items(25, 1'b1);
    settle();

    // One-byte streams: every output byte completes its stream.
    tx_stall = 1'b1;
    write_length(16'd1);
    random_items(10, 1'b0);
    settle();

    // Closing part without any idling.
    tx_stall = 1'b0;
    rx_stall = 1'b0;
    write_length(16'($urandom_range(2, 64)));
    random_items(30, 1'b0);
    settle();

    if (model.pending() != 0) model.flag_error("bytes still owed at the end");
    if (model.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lzss_pkg.sv
rtl/core/lzss_window_ram.sv
rtl/core/lzss_ctrl.sv
rtl/core/lzss_12_4_decompressor_core.sv
tb/tb.sv
